// File: hdl/stdc_pkg.sv
// Shared types, constants and hit-test helper for the settable time-of-day clock.
package stdc_pkg;

	localparam logic [15:0] DEFAULT_PERIOD = 16'd1000;

	localparam logic [5:0] SEC_RESET  = 6'd55;
	localparam logic [5:0] MIN_RESET  = 6'd59;
	localparam logic [4:0] HOUR_RESET = 5'd23;

	localparam logic [5:0] SEC_MAX  = 6'd59;
	localparam logic [5:0] MIN_MAX  = 6'd59;
	localparam logic [4:0] HOUR_MAX = 5'd23;

	// Screen rectangles, open bounds: lo < coord < hi
	localparam logic [7:0] ENTER_XL = 8'd55;
	localparam logic [7:0] ENTER_XH = 8'd170;
	localparam logic [7:0] ENTER_YL = 8'd25;
	localparam logic [7:0] ENTER_YH = 8'd60;

	localparam logic [7:0] SAVE_XL = 8'd60;
	localparam logic [7:0] SAVE_XH = 8'd180;
	localparam logic [7:0] SAVE_YL = 8'd190;
	localparam logic [7:0] SAVE_YH = 8'd230;

	localparam logic [7:0] HOUR_BTN_XL = 8'd60;
	localparam logic [7:0] HOUR_BTN_XH = 8'd75;
	localparam logic [7:0] MIN_BTN_XL  = 8'd110;
	localparam logic [7:0] MIN_BTN_XH  = 8'd125;
	localparam logic [7:0] UP_BTN_YL   = 8'd75;
	localparam logic [7:0] UP_BTN_YH   = 8'd110;
	localparam logic [7:0] DOWN_BTN_YL = 8'd140;
	localparam logic [7:0] DOWN_BTN_YH = 8'd175;

	localparam logic FUNC_TICK  = 1'b0;
	localparam logic FUNC_TOUCH = 1'b1;

	typedef struct packed {
		logic enter;
		logic save;
		logic hour_up;
		logic hour_down;
		logic min_up;
		logic min_down;
	} touch_hit_t;

	function automatic logic in_rect(input logic [7:0] x, input logic [7:0] y,
		input logic [7:0] xl, input logic [7:0] xh,
		input logic [7:0] yl, input logic [7:0] yh);
		return (x > xl) && (x < xh) && (y > yl) && (y < yh);
	endfunction

endpackage

// File: hdl/stdc_touch.sv
// Touch hit-test decoder: maps a coordinate onto the fixed screen buttons.
module stdc_touch (
	input  logic [7:0]              touch_x,
	input  logic [7:0]              touch_y,
	output stdc_pkg::touch_hit_t    hit
);

	always_comb begin
		hit.enter     = stdc_pkg::in_rect(touch_x, touch_y,
			stdc_pkg::ENTER_XL, stdc_pkg::ENTER_XH,
			stdc_pkg::ENTER_YL, stdc_pkg::ENTER_YH);
		hit.save      = stdc_pkg::in_rect(touch_x, touch_y,
			stdc_pkg::SAVE_XL, stdc_pkg::SAVE_XH,
			stdc_pkg::SAVE_YL, stdc_pkg::SAVE_YH);
		hit.hour_up   = stdc_pkg::in_rect(touch_x, touch_y,
			stdc_pkg::HOUR_BTN_XL, stdc_pkg::HOUR_BTN_XH,
			stdc_pkg::UP_BTN_YL, stdc_pkg::UP_BTN_YH);
		hit.hour_down = stdc_pkg::in_rect(touch_x, touch_y,
			stdc_pkg::HOUR_BTN_XL, stdc_pkg::HOUR_BTN_XH,
			stdc_pkg::DOWN_BTN_YL, stdc_pkg::DOWN_BTN_YH);
		hit.min_up    = stdc_pkg::in_rect(touch_x, touch_y,
			stdc_pkg::MIN_BTN_XL, stdc_pkg::MIN_BTN_XH,
			stdc_pkg::UP_BTN_YL, stdc_pkg::UP_BTN_YH);
		hit.min_down  = stdc_pkg::in_rect(touch_x, touch_y,
			stdc_pkg::MIN_BTN_XL, stdc_pkg::MIN_BTN_XH,
			stdc_pkg::DOWN_BTN_YL, stdc_pkg::DOWN_BTN_YH);
	end

endmodule

// File: hdl/stdc_time.sv
// Time-of-day state registers with prescaler, carries and set-mode adjustments.
module stdc_time (
	input  logic                    clk,
	input  logic                    arst_n,
	input  logic                    step,
	input  logic                    func,
	input  stdc_pkg::touch_hit_t    hit,
	input  logic [15:0]             period,
	output logic [4:0]              hours,
	output logic [5:0]              minutes,
	output logic [5:0]              seconds,
	output logic                    set_mode
);

	logic [15:0] ms_q, ms_d, ms_inc;
	logic [5:0]  sec_q, sec_d;
	logic [5:0]  min_q, min_d;
	logic [4:0]  hour_q, hour_d;
	logic        flag_q, flag_d;
	logic        flag_mid;
	logic        sec_tick;
	logic        inc_min, dec_min, inc_hour, dec_hour;

	always_comb begin
		ms_d     = ms_q;
		sec_d    = sec_q;
		min_d    = min_q;
		hour_d   = hour_q;
		flag_d   = flag_q;
		inc_min  = 1'b0;
		dec_min  = 1'b0;
		inc_hour = 1'b0;
		dec_hour = 1'b0;
		ms_inc   = ms_q + 16'd1;
		// a zero period behaves as one, and a counter wrap also fires
		sec_tick = (ms_inc >= period) || (ms_inc == 16'd0);
		flag_mid = flag_q;

		if (func == stdc_pkg::FUNC_TICK) begin
			if (sec_tick) begin
				ms_d = 16'd0;
				if (sec_q >= stdc_pkg::SEC_MAX) begin
					sec_d   = 6'd0;
					inc_min = 1'b1;
				end else begin
					sec_d = sec_q + 6'd1;
				end
			end else begin
				ms_d = ms_inc;
			end
		end else begin
			if (hit.enter) begin
				flag_mid = 1'b1;
			end
			if (hit.save) begin
				flag_mid = 1'b0;
			end
			flag_d = flag_mid;
			if (flag_mid) begin
				priority if (hit.hour_up) begin
					inc_hour = 1'b1;
				end else if (hit.hour_down) begin
					dec_hour = 1'b1;
				end else if (hit.min_up) begin
					inc_min = 1'b1;
				end else if (hit.min_down) begin
					dec_min = 1'b1;
				end else begin
					// no button hit: hold the time
				end
			end
		end

		if (inc_min) begin
			if (min_q >= stdc_pkg::MIN_MAX) begin
				min_d    = 6'd0;
				inc_hour = 1'b1;
			end else begin
				min_d = min_q + 6'd1;
			end
		end else if (dec_min) begin
			if ((min_q == 6'd0) || (min_q > stdc_pkg::MIN_MAX)) begin
				min_d    = stdc_pkg::MIN_MAX;
				dec_hour = 1'b1;
			end else begin
				min_d = min_q - 6'd1;
			end
		end

		if (inc_hour) begin
			hour_d = (hour_q >= stdc_pkg::HOUR_MAX) ? 5'd0 : hour_q + 5'd1;
		end else if (dec_hour) begin
			hour_d = ((hour_q == 5'd0) || (hour_q > stdc_pkg::HOUR_MAX)) ?
				stdc_pkg::HOUR_MAX : hour_q - 5'd1;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ms_q   <= 16'd0;
			sec_q  <= stdc_pkg::SEC_RESET;
			min_q  <= stdc_pkg::MIN_RESET;
			hour_q <= stdc_pkg::HOUR_RESET;
			flag_q <= 1'b0;
		end else if (step) begin
			ms_q   <= ms_d;
			sec_q  <= sec_d;
			min_q  <= min_d;
			hour_q <= hour_d;
			flag_q <= flag_d;
		end
	end

	assign hours    = hour_q;
	assign minutes  = min_q;
	assign seconds  = sec_q;
	assign set_mode = flag_q;

	// a touch never moves the seconds or the prescaler
	a_touch_keeps_seconds: assert property (@(posedge clk) disable iff (!arst_n)
		(step && func == stdc_pkg::FUNC_TOUCH) |=> ($stable(sec_q) && $stable(ms_q)))
		else $error("touch item changed seconds or prescaler");

	a_time_in_range: assert property (@(posedge clk) disable iff (!arst_n)
		(hour_q <= stdc_pkg::HOUR_MAX) && (min_q <= stdc_pkg::MIN_MAX)
			&& (sec_q <= stdc_pkg::SEC_MAX))
		else $error("time register out of range");

	// a tick never changes the set-mode flag
	a_tick_keeps_flag: assert property (@(posedge clk) disable iff (!arst_n)
		(step && func == stdc_pkg::FUNC_TICK) |=> $stable(flag_q))
		else $error("tick item changed set mode");

endmodule

// File: hdl/settable_time_of_day_clock_unit.sv
// Top level of the settable time-of-day clock: handshakes, input stage, result valid.
//
// Usage:
//   Input channel (in_valid / in_stall, fields func, touch_x, touch_y) carries
//   either a millisecond tick (func 0) or a touch event (func 1). Each item
//   yields one result on the output channel (out_valid / out_stall, fields
//   hours, minutes, seconds, set_mode) showing the time after that item.
//   The configuration channel (cfg_valid / cfg_ready, cfg_data) writes the
//   tick count per second; cfg_ready is always high. Write it only when idle.
// Flow: an accepted item is registered in the input register, then stepped into the
//   time state registers, which hold its result. Throughput: one item per cycle
//   while no result is stalled; these registers double as the result register, so
//   the next item is taken while a result waits, if the input register can move on.
// Reset: the clock reads 23:59:55, set mode off, period 1000, no result pending.
// Stall: while out_stall holds a pending result, the input register keeps its
//   item and in_stall rises once that register is full; the result stays put.
module settable_time_of_day_clock_unit (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        in_valid,
	output logic        in_stall,
	input  logic        func,
	input  logic [7:0]  touch_x,
	input  logic [7:0]  touch_y,
	output logic        out_valid,
	input  logic        out_stall,
	output logic [4:0]  hours,
	output logic [5:0]  minutes,
	output logic [5:0]  seconds,
	output logic        set_mode,
	input  logic        cfg_valid,
	output logic        cfg_ready,
	input  logic [15:0] cfg_data
);

	logic        valid_s1;
	logic        func_s1;
	logic [7:0]  x_s1, y_s1;
	logic [15:0] period_q;
	logic        out_valid_q;
	logic        advance;
	logic        in_take;
	logic        step;
	stdc_pkg::touch_hit_t hit;

	assign advance   = !out_valid_q || !out_stall;
	assign step      = valid_s1 && advance;
	assign in_stall  = valid_s1 && !advance;
	assign in_take   = in_valid && !in_stall;
	assign cfg_ready = 1'b1;
	assign out_valid = out_valid_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1    <= 1'b0;
			out_valid_q <= 1'b0;
			period_q    <= stdc_pkg::DEFAULT_PERIOD;
		end else begin
			if (in_take) begin
				valid_s1 <= 1'b1;
			end else if (step) begin
				valid_s1 <= 1'b0;
			end
			if (step) begin
				out_valid_q <= 1'b1;
			end else if (!out_stall) begin
				out_valid_q <= 1'b0;
			end
			if (cfg_valid && cfg_ready) begin
				period_q <= cfg_data;
			end
		end
	end

	// payload of the input register, no reset needed
	always_ff @(posedge clk) begin
		if (in_take) begin
			func_s1 <= func;
			x_s1    <= touch_x;
			y_s1    <= touch_y;
		end
	end

	stdc_touch u_touch (
		.touch_x (x_s1),
		.touch_y (y_s1),
		.hit     (hit)
	);

	stdc_time u_time (
		.clk      (clk),
		.arst_n   (arst_n),
		.step     (step),
		.func     (func_s1),
		.hit      (hit),
		.period   (period_q),
		.hours    (hours),
		.minutes  (minutes),
		.seconds  (seconds),
		.set_mode (set_mode)
	);

	// every processed item must raise a result next cycle
	a_step_gives_result: assert property (@(posedge clk) disable iff (!arst_n)
		step |=> out_valid_q)
		else $error("processed item produced no result");

	// a stalled result keeps its time fields
	a_stalled_result_holds: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid_q && out_stall) |=> ($stable(hours) && $stable(minutes)
			&& $stable(seconds) && $stable(set_mode)))
		else $error("result changed while stalled");

	// input back-pressure only when the input register is full and blocked
	a_stall_cause: assert property (@(posedge clk) disable iff (!arst_n)
		in_stall |-> (valid_s1 && out_valid_q && out_stall))
		else $error("input stalled without a blocked item");

endmodule

// File: test/settable_time_of_day_clock_checker.sv
// Checker for the time-of-day clock unit: watches all channels, predicts each result and compares it.
`timescale 1ns / 100ps
module settable_time_of_day_clock_checker (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        in_valid,
	input  logic        in_stall,
	input  logic        func,
	input  logic [7:0]  touch_x,
	input  logic [7:0]  touch_y,
	input  logic        out_valid,
	input  logic        out_stall,
	input  logic [4:0]  hours,
	input  logic [5:0]  minutes,
	input  logic [5:0]  seconds,
	input  logic        set_mode,
	input  logic        cfg_valid,
	input  logic        cfg_ready,
	input  logic [15:0] cfg_data,
	output int          outstanding,
	output int          fail_count
);

	typedef struct packed {
		logic [4:0] hours;
		logic [5:0] minutes;
		logic [5:0] seconds;
		logic       set_mode;
	} clock_face_t;

	logic [15:0] period;
	logic [15:0] ms_count;
	clock_face_t face;
	clock_face_t expected_faces[$];

	initial fail_count = 0;

	function automatic logic in_box(input logic [7:0] x, input logic [7:0] y,
		input logic [7:0] xl, input logic [7:0] xh,
		input logic [7:0] yl, input logic [7:0] yh);
		return x > xl && x < xh && y > yl && y < yh;
	endfunction

	function automatic logic [4:0] next_hour(input logic [4:0] h);
		return (h >= stdc_pkg::HOUR_MAX) ? 5'd0 : h + 5'd1;
	endfunction

	function automatic logic [4:0] prev_hour(input logic [4:0] h);
		return (h == 5'd0 || h > stdc_pkg::HOUR_MAX) ? stdc_pkg::HOUR_MAX : h - 5'd1;
	endfunction

	function automatic void step_minute(input logic up);
		if (up) begin
			if (face.minutes >= stdc_pkg::MIN_MAX) begin
				face.minutes = 6'd0;
				face.hours = next_hour(face.hours);
			end else begin
				face.minutes = face.minutes + 6'd1;
			end
		end else begin
			if (face.minutes == 6'd0 || face.minutes > stdc_pkg::MIN_MAX) begin
				face.minutes = stdc_pkg::MIN_MAX;
				face.hours = prev_hour(face.hours);
			end else begin
				face.minutes = face.minutes - 6'd1;
			end
		end
	endfunction

	function automatic void advance_clock(input logic f, input logic [7:0] x,
		input logic [7:0] y);
		if (f == stdc_pkg::FUNC_TICK) begin
			ms_count = ms_count + 16'd1;
			// a zero period advances on every tick
			if (ms_count >= period || ms_count == 16'd0) begin
				ms_count = 16'd0;
				if (face.seconds >= stdc_pkg::SEC_MAX) begin
					face.seconds = 6'd0;
					step_minute(1'b1);
				end else begin
					face.seconds = face.seconds + 6'd1;
				end
			end
		end else begin
			if (in_box(x, y, stdc_pkg::ENTER_XL, stdc_pkg::ENTER_XH,
				stdc_pkg::ENTER_YL, stdc_pkg::ENTER_YH))
				face.set_mode = 1'b1;
			if (in_box(x, y, stdc_pkg::SAVE_XL, stdc_pkg::SAVE_XH,
				stdc_pkg::SAVE_YL, stdc_pkg::SAVE_YH))
				face.set_mode = 1'b0;
			if (face.set_mode) begin
				if (in_box(x, y, stdc_pkg::HOUR_BTN_XL, stdc_pkg::HOUR_BTN_XH,
					stdc_pkg::UP_BTN_YL, stdc_pkg::UP_BTN_YH))
					face.hours = next_hour(face.hours);
				else if (in_box(x, y, stdc_pkg::HOUR_BTN_XL, stdc_pkg::HOUR_BTN_XH,
					stdc_pkg::DOWN_BTN_YL, stdc_pkg::DOWN_BTN_YH))
					face.hours = prev_hour(face.hours);
				else if (in_box(x, y, stdc_pkg::MIN_BTN_XL, stdc_pkg::MIN_BTN_XH,
					stdc_pkg::UP_BTN_YL, stdc_pkg::UP_BTN_YH))
					step_minute(1'b1);
				else if (in_box(x, y, stdc_pkg::MIN_BTN_XL, stdc_pkg::MIN_BTN_XH,
					stdc_pkg::DOWN_BTN_YL, stdc_pkg::DOWN_BTN_YH))
					step_minute(1'b0);
			end
		end
	endfunction

	always @(posedge clk or negedge arst_n) begin : watch
		clock_face_t got;
		clock_face_t want;
		if (!arst_n) begin
			period = stdc_pkg::DEFAULT_PERIOD;
			ms_count = 16'd0;
			face = '{stdc_pkg::HOUR_RESET, stdc_pkg::MIN_RESET, stdc_pkg::SEC_RESET, 1'b0};
			expected_faces.delete();
			outstanding <= 0;
		end else begin
			if (cfg_valid && cfg_ready)
				period = cfg_data;
			// retire the result first so an early result cannot match this edge's item
			if (out_valid && !out_stall) begin
				got = '{hours, minutes, seconds, set_mode};
				if (expected_faces.size() == 0) begin
					if (fail_count < 10)
						$display("unexpected result %0d:%0d:%0d set_mode %0b",
							got.hours, got.minutes, got.seconds, got.set_mode);
					fail_count++;
				end else begin
					want = expected_faces.pop_front();
					if (got.hours !== want.hours || got.minutes !== want.minutes ||
						got.seconds !== want.seconds || got.set_mode !== want.set_mode) begin
						if (fail_count < 10)
							$display({"result mismatch: expected %0d:%0d:%0d set_mode %0b,",
								" got %0d:%0d:%0d set_mode %0b"},
								want.hours, want.minutes, want.seconds, want.set_mode,
								got.hours, got.minutes, got.seconds, got.set_mode);
						fail_count++;
					end
				end
			end
			if (in_valid && !in_stall) begin
				advance_clock(func, touch_x, touch_y);
				expected_faces.push_back(face);
			end
			outstanding <= expected_faces.size();
		end
	end

endmodule

// File: test/tb_settable_time_of_day_clock_unit.sv
// Testbench top for the time-of-day clock unit: clock, reset, stimulus and verdict.
`timescale 1ns / 100ps
module tb_settable_time_of_day_clock_unit;

	logic        clk = 1'b0;
	logic        arst_n;
	logic        in_valid;
	logic        in_stall;
	logic        func;
	logic [7:0]  touch_x;
	logic [7:0]  touch_y;
	logic        out_valid;
	logic        out_stall;
	logic [4:0]  hours;
	logic [5:0]  minutes;
	logic [5:0]  seconds;
	logic        set_mode;
	logic        cfg_valid;
	logic        cfg_ready;
	logic [15:0] cfg_data;

	int outstanding;
	int fail_count;
	int gap_pct = 0;
	int stall_pct = 0;
	logic [15:0] periods [8];

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	settable_time_of_day_clock_unit i_dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_stall  (in_stall),
		.func      (func),
		.touch_x   (touch_x),
		.touch_y   (touch_y),
		.out_valid (out_valid),
		.out_stall (out_stall),
		.hours     (hours),
		.minutes   (minutes),
		.seconds   (seconds),
		.set_mode  (set_mode),
		.cfg_valid (cfg_valid),
		.cfg_ready (cfg_ready),
		.cfg_data  (cfg_data)
	);

	settable_time_of_day_clock_checker i_checker (
		.clk         (clk),
		.arst_n      (arst_n),
		.in_valid    (in_valid),
		.in_stall    (in_stall),
		.func        (func),
		.touch_x     (touch_x),
		.touch_y     (touch_y),
		.out_valid   (out_valid),
		.out_stall   (out_stall),
		.hours       (hours),
		.minutes     (minutes),
		.seconds     (seconds),
		.set_mode    (set_mode),
		.cfg_valid   (cfg_valid),
		.cfg_ready   (cfg_ready),
		.cfg_data    (cfg_data),
		.outstanding (outstanding),
		.fail_count  (fail_count)
	);

	initial begin
		#5_000_000;
		$display("tb_settable_time_of_day_clock_unit NOT OK");
		$finish;
	end

	// receiver side: stall in random bursts
	initial begin
		out_stall <= 1'b0;
		forever begin
			@(posedge clk);
			if ($urandom_range(0, 99) < stall_pct) begin
				out_stall <= 1'b1;
				repeat ($urandom_range(1, 7)) @(posedge clk);
				out_stall <= 1'b0;
			end
		end
	end

	task automatic send_item(input logic f, input logic [7:0] x, input logic [7:0] y);
		if ($urandom_range(0, 99) < gap_pct) begin
			in_valid <= 1'b0;
			repeat ($urandom_range(1, 7)) @(posedge clk);
		end
		in_valid <= 1'b1;
		func <= f;
		touch_x <= x;
		touch_y <= y;
		@(posedge clk);
		while (in_stall) @(posedge clk);
	endtask

	task automatic send_random_touch();
		logic [7:0] x;
		logic [7:0] y;
		case ($urandom_range(0, 7))
			0: begin
				x = 8'($urandom_range(stdc_pkg::ENTER_XL, stdc_pkg::ENTER_XH));
				y = 8'($urandom_range(stdc_pkg::ENTER_YL, stdc_pkg::ENTER_YH));
			end
			1: begin
				x = 8'($urandom_range(stdc_pkg::SAVE_XL, stdc_pkg::SAVE_XH));
				y = 8'($urandom_range(stdc_pkg::SAVE_YL, stdc_pkg::SAVE_YH));
			end
			2: begin
				x = 8'($urandom_range(stdc_pkg::HOUR_BTN_XL, stdc_pkg::HOUR_BTN_XH));
				y = 8'($urandom_range(stdc_pkg::UP_BTN_YL, stdc_pkg::UP_BTN_YH));
			end
			3: begin
				x = 8'($urandom_range(stdc_pkg::HOUR_BTN_XL, stdc_pkg::HOUR_BTN_XH));
				y = 8'($urandom_range(stdc_pkg::DOWN_BTN_YL, stdc_pkg::DOWN_BTN_YH));
			end
			4: begin
				x = 8'($urandom_range(stdc_pkg::MIN_BTN_XL, stdc_pkg::MIN_BTN_XH));
				y = 8'($urandom_range(stdc_pkg::UP_BTN_YL, stdc_pkg::UP_BTN_YH));
			end
			5: begin
				x = 8'($urandom_range(stdc_pkg::MIN_BTN_XL, stdc_pkg::MIN_BTN_XH));
				y = 8'($urandom_range(stdc_pkg::DOWN_BTN_YL, stdc_pkg::DOWN_BTN_YH));
			end
			default: begin
				x = 8'($urandom_range(0, 239));
				y = 8'($urandom_range(0, 239));
			end
		endcase
		send_item(stdc_pkg::FUNC_TOUCH, x, y);
	endtask

	// hold the sender until every result is back
	task automatic wait_settled();
		in_valid <= 1'b0;
		do @(posedge clk); while (outstanding != 0);
	endtask

	task automatic write_period(input logic [15:0] value);
		cfg_valid <= 1'b1;
		cfg_data <= value;
		@(posedge clk);
		while (!cfg_ready) @(posedge clk);
		cfg_valid <= 1'b0;
	endtask

	initial begin
		arst_n <= 1'b0;
		in_valid <= 1'b0;
		func <= stdc_pkg::FUNC_TICK;
		touch_x <= 8'd0;
		touch_y <= 8'd0;
		cfg_valid <= 1'b0;
		cfg_data <= 16'd0;
		repeat (2) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// buttons outside set mode, then each button and its wrap inside set mode
		send_item(stdc_pkg::FUNC_TOUCH, 8'd67, 8'd90);
		send_item(stdc_pkg::FUNC_TOUCH, 8'd55, 8'd40);
		send_item(stdc_pkg::FUNC_TOUCH, 8'd56, 8'd26);
		send_item(stdc_pkg::FUNC_TOUCH, 8'd67, 8'd90);
		send_item(stdc_pkg::FUNC_TOUCH, 8'd67, 8'd150);
		send_item(stdc_pkg::FUNC_TOUCH, 8'd74, 8'd109);
		send_item(stdc_pkg::FUNC_TOUCH, 8'd60, 8'd90);
		send_item(stdc_pkg::FUNC_TOUCH, 8'd115, 8'd90);
		send_item(stdc_pkg::FUNC_TOUCH, 8'd115, 8'd150);
		send_item(stdc_pkg::FUNC_TOUCH, 8'd124, 8'd174);
		send_item(stdc_pkg::FUNC_TOUCH, 8'd115, 8'd90);
		send_item(stdc_pkg::FUNC_TOUCH, 8'd61, 8'd141);
		send_item(stdc_pkg::FUNC_TOUCH, 8'd239, 8'd239);
		send_item(stdc_pkg::FUNC_TOUCH, 8'd0, 8'd0);
		send_item(stdc_pkg::FUNC_TOUCH, 8'd169, 8'd59);
		send_item(stdc_pkg::FUNC_TOUCH, 8'd179, 8'd229);
		send_item(stdc_pkg::FUNC_TOUCH, 8'd115, 8'd90);
		wait_settled();

		// one tick per second: roll over midnight
		write_period(16'd1);
		repeat (6) send_item(stdc_pkg::FUNC_TICK, 8'hFF, 8'hA5);
		wait_settled();
		write_period(16'd0);
		repeat (2) send_item(stdc_pkg::FUNC_TICK, 8'h00, 8'h5A);

		periods = '{16'd2, 16'hFFFF, 16'd0, 16'd60, stdc_pkg::DEFAULT_PERIOD, 16'd7,
			16'd1, 16'd1};
		periods[6] = 16'($urandom_range(1, 65535));
		for (int p = 0; p < 8; p++) begin
			wait_settled();
			write_period(periods[p]);
			gap_pct = (p == 7 || p == 2) ? 0 : 15 + 5 * p;
			stall_pct = (p == 7 || p == 4) ? 0 : 10 + 5 * p;
			repeat (204) begin
				if ($urandom_range(0, 1) == 0)
					send_item(stdc_pkg::FUNC_TICK, 8'($urandom_range(0, 255)),
						8'($urandom_range(0, 255)));
				else
					send_random_touch();
			end
		end

		wait_settled();
		repeat (4) @(posedge clk);
		@(negedge clk);
		if (fail_count == 0)
			$display("tb_settable_time_of_day_clock_unit OK");
		else
			$display("tb_settable_time_of_day_clock_unit NOT OK");
		$finish;
	end

endmodule
